@@ design/lpht_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared codes, defaults and types for the linear-probe hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

    // Default sizes
    localparam int TABLE_SIZE_DEF = 16;
    localparam int KEY_WIDTH_DEF  = 32;

    // Result field widths
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int MODE_W   = 2;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO_KEY  = 2'd3;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic              start;  // load the probe token at the home cell
        logic              probe;  // cells compare and hand the token on
        logic [MODE_W-1:0] mode;   // operation of the current request
    } t_ctl;

endpackage

@@ design/lpht_home.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_home
// Home slot unit: key mod table size. One registered step for a power-of-two
// table; otherwise the key bytes are folded with their weights 2^(8*j) mod
// table size, one byte per cycle, and the folded sum is reduced by a
// registered reciprocal multiply and then a registered multiply-subtract.
// ----------------------------------------------------------------------------
module lpht_home
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int KEY_WIDTH  = KEY_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [KEY_WIDTH-1:0]          i_key,
    output logic                          o_done,
    output logic [$clog2(TABLE_SIZE)-1:0] o_home
);

    localparam int  IDX_W   = $clog2(TABLE_SIZE);
    localparam bit  IS_POW2 = ((1 << IDX_W) == TABLE_SIZE);

    generate
        if (IS_POW2) begin : g_pow2
            localparam int KX_W = (KEY_WIDTH > IDX_W) ? KEY_WIDTH : IDX_W;

            logic [KX_W-1:0]  w_key_x;
            logic             r_done;
            logic [IDX_W-1:0] r_home;

            assign w_key_x = KX_W'(i_key);

            // Take the low key bits as the home slot
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
                if (i_start) begin
                    r_home <= w_key_x[IDX_W-1:0];
                end
            end

            assign o_done = r_done;
            assign o_home = r_home;
        end else begin : g_fold
            localparam int NCHUNK = (KEY_WIDTH + 7) / 8;
            localparam int KEY_PW = NCHUNK * 8;
            localparam int LEFT_W = $clog2(NCHUNK + 1);
            localparam int TERM_W = 8 + IDX_W;
            // Up to eight byte terms, each below 2^8 * TABLE_SIZE
            localparam int ACC_W  = IDX_W + 11;
            localparam int SHIFT  = ACC_W + IDX_W;
            localparam int RCP_W  = ACC_W + 1;
            localparam int PROD_W = ACC_W + RCP_W;
            localparam int Q_W    = PROD_W - SHIFT;
            localparam logic [63:0] RECIP = ((64'd1 << SHIFT) / 64'(TABLE_SIZE)) + 64'd1;

            logic [NCHUNK*IDX_W-1:0] w_wts;
            logic [TERM_W-1:0]       w_term;
            logic [PROD_W-1:0]       w_prod;
            logic [ACC_W-1:0]        w_qn;
            logic [ACC_W-1:0]        w_diff;
            logic [KEY_PW-1:0]       r_key;
            logic [NCHUNK*IDX_W-1:0] r_wts;
            logic [LEFT_W-1:0]       r_left;
            logic [ACC_W-1:0]        r_acc;
            logic                    r_qv;
            logic                    r_rv;
            logic                    r_done;
            logic [Q_W-1:0]          r_q;
            logic [IDX_W-1:0]        r_rem;

            // Weight of key byte j: 2^(8*j) mod table size
            for (genvar j = 0; j < NCHUNK; j++) begin : g_wt
                assign w_wts[j*IDX_W +: IDX_W] =
                    IDX_W'((64'd1 << (8 * j)) % 64'(TABLE_SIZE));
            end

            // Weighted byte, quotient estimate and remainder
            assign w_term = TERM_W'(r_key[7:0]) * TERM_W'(r_wts[IDX_W-1:0]);
            assign w_prod = PROD_W'(r_acc) * PROD_W'(RECIP[RCP_W-1:0]);
            assign w_qn   = ACC_W'(r_q) * ACC_W'(TABLE_SIZE);
            assign w_diff = r_acc - w_qn;

            // Count the byte steps, then advance through quotient and remainder
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_left <= '0;
                    r_qv   <= 1'b0;
                    r_rv   <= 1'b0;
                    r_done <= 1'b0;
                end else begin
                    if (i_start) begin
                        r_left <= LEFT_W'(NCHUNK);
                    end else if (r_left != '0) begin
                        r_left <= r_left - 1'b1;
                    end
                    r_qv   <= !i_start && (r_left == LEFT_W'(1));
                    r_rv   <= r_qv;
                    r_done <= r_rv;
                end
            end

            // Fold one key byte per cycle into the accumulator
            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_key <= KEY_PW'(i_key);
                    r_wts <= w_wts;
                    r_acc <= '0;
                end else if (r_left != '0) begin
                    r_key <= r_key >> 8;
                    r_wts <= r_wts >> IDX_W;
                    r_acc <= r_acc + ACC_W'(w_term);
                end
                if (r_qv) begin
                    r_q <= w_prod[SHIFT +: Q_W];
                end
                if (r_rv) begin
                    r_rem <= w_diff[IDX_W-1:0];
                end
            end

            assign o_done = r_done;
            assign o_home = r_rem;
        end
    endgenerate

endmodule

@@ design/lpht_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_cell
// One table slot. Holds a key, checks it while it holds the probe token,
// and either claims the request or hands the token to the next slot.
// ----------------------------------------------------------------------------
module lpht_cell
    import lpht_pkg::*;
#(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    parameter int IDX_W     = 4,
    parameter int CELL_IDX  = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctl                 i_ctl,
    input  logic [KEY_WIDTH-1:0] i_key,
    input  logic [IDX_W-1:0]     i_home,
    input  logic                 i_tok,
    output logic                 o_tok,
    output logic                 o_hit
);

    logic [KEY_WIDTH-1:0] r_slot;
    logic                 r_tok;
    logic                 w_match;

    // Insert looks for an empty slot, search and delete for the key
    assign w_match = (i_ctl.mode == MODE_INSERT) ? (r_slot == '0) : (r_slot == i_key);
    assign o_hit   = r_tok && i_ctl.probe && w_match;
    assign o_tok   = r_tok && i_ctl.probe && !w_match;

    // Load the token at home, pass it along while probing, drop it otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else if (i_ctl.start) begin
            r_tok <= (i_home == IDX_W'(CELL_IDX));
        end else if (i_ctl.probe) begin
            r_tok <= i_tok;
        end else begin
            r_tok <= 1'b0;
        end
    end

    // Write the key on insert, clear it on delete
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (o_hit && (i_ctl.mode == MODE_INSERT)) begin
            r_slot <= i_key;
        end else if (o_hit && (i_ctl.mode == MODE_DELETE)) begin
            r_slot <= '0;
        end
    end

endmodule

@@ design/linear_probe_hash_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Open-addressing hash table of nonzero keys with linear probing.
// ----------------------------------------------------------------------------
// One request at a time. A request with a zero key or an unused mode gives its
// result the cycle after it is taken. Otherwise the home slot (key mod
// TABLE_SIZE) is the registered low key bits for a power-of-two TABLE_SIZE
// and comes from the byte fold and reduction for any other size; then a probe
// token walks the ring of slot cells, one slot per cycle, until a cell claims
// the request or every slot has been probed, and the result register is loaded
// at the end of the last probe cycle. The slots reset to empty at once.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int KEY_WIDTH  = KEY_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [1:0] mode, [KEY_WIDTH+1:2] key, zero fill above
    input  logic [((MODE_W+KEY_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] status, [5:2] slot_index, [7:6] zero
    output logic [7:0]                          m_axis_tdata
);

    localparam int IDX_W  = $clog2(TABLE_SIZE);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_HOME  = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [MODE_W-1:0]     r_mode;
    logic [KEY_WIDTH-1:0]  r_key;
    logic [IDX_W-1:0]      r_idx;
    logic [IDX_W-1:0]      n_idx;
    logic [IDX_W-1:0]      r_cnt;
    logic [IDX_W-1:0]      n_cnt;
    logic [STATUS_W-1:0]   r_status;
    logic [STATUS_W-1:0]   n_status;
    logic [SLOT_W-1:0]     r_slot;
    logic [SLOT_W-1:0]     n_slot;

    logic [MODE_W-1:0]     w_in_mode;
    logic [KEY_WIDTH-1:0]  w_in_key;
    logic                  w_accept;
    logic                  w_home_start;
    logic                  w_home_done;
    logic [IDX_W-1:0]      w_home;
    logic                  w_any_hit;
    t_ctl                  w_ctl;
    logic [TABLE_SIZE-1:0] w_tok;
    logic [TABLE_SIZE-1:0] w_hit;

    // Unpack the request
    assign w_in_mode = s_axis_tdata[MODE_W-1:0];
    assign w_in_key  = s_axis_tdata[MODE_W+KEY_WIDTH-1:MODE_W];
    assign w_accept  = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {{(8 - STATUS_W - SLOT_W){1'b0}}, r_slot, r_status};

    // Start the home computation only for real work
    assign w_home_start = w_accept && (w_in_key != '0)
                       && (w_in_mode != MODE_SEARCH + MODE_DELETE);

    lpht_home #(
        .TABLE_SIZE (TABLE_SIZE),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_home (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_home_start),
        .i_key   (w_in_key),
        .o_done  (w_home_done),
        .o_home  (w_home)
    );

    // Broadcast control to the cell ring
    assign w_ctl.start = (r_state == S_HOME) && w_home_done;
    assign w_ctl.probe = (r_state == S_PROBE);
    assign w_ctl.mode  = r_mode;

    genvar g;
    generate
        for (g = 0; g < TABLE_SIZE; g++) begin : g_cell
            lpht_cell #(
                .KEY_WIDTH (KEY_WIDTH),
                .IDX_W     (IDX_W),
                .CELL_IDX  (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_key   (r_key),
                .i_home  (w_home),
                .i_tok   (w_tok[(g + TABLE_SIZE - 1) % TABLE_SIZE]),
                .o_tok   (w_tok[g]),
                .o_hit   (w_hit[g])
            );
        end
    endgenerate

    assign w_any_hit = |w_hit;

    // Sequence one request: home, probe, present the result
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_status = r_status;
        n_slot   = r_slot;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_slot = '0;
                    if (w_in_key == '0) begin
                        n_status = ST_ZERO_KEY;
                        n_state  = S_OUT;
                    end else if (w_in_mode == MODE_SEARCH + MODE_DELETE) begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_HOME;
                    end
                end
            end
            S_HOME: begin
                if (w_home_done) begin
                    n_idx   = w_home;
                    n_cnt   = '0;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (w_any_hit) begin
                    n_status = ST_OK;
                    n_slot   = SLOT_W'(r_idx);
                    n_state  = S_OUT;
                end else if (r_cnt == IDX_W'(TABLE_SIZE - 1)) begin
                    n_status = (r_mode == MODE_INSERT) ? ST_FULL : ST_NOT_FOUND;
                    n_slot   = '0;
                    n_state  = S_OUT;
                end else begin
                    n_idx = (r_idx == IDX_W'(TABLE_SIZE - 1)) ? '0 : r_idx + 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the request and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= w_in_mode;
            r_key  <= w_in_key;
        end
        r_idx    <= n_idx;
        r_cnt    <= n_cnt;
        r_status <= n_status;
        r_slot   <= n_slot;
    end

    // At most one cell holds the token or claims the request
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok) && $onehot0(w_hit))
        else $error("more than one probe token in the ring");

    // A failed request reports slot zero
    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_status != ST_OK)) |-> (r_slot == '0))
        else $error("nonzero slot on a failed request");

    // No new request is taken while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken while a result is pending");

    // Cells act only while probing
    a_hit_in_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_any_hit |-> (r_state == S_PROBE))
        else $error("cell claimed a request outside the probe phase");

endmodule
